FILE: rtl/igf_pkg.sv
// Package for the idle-gap first-fit reserver.
// Holds default sizes, mode and status codes and the controller state type.
// No dependencies.
`default_nettype none
package igf_pkg;
  localparam int IGF_MAX_GAPS_DEF = 64;
  localparam int IGF_TIME_BITS_DEF = 48;

  localparam logic [2:0] MODE_RESERVE = 3'd0;
  localparam logic [2:0] MODE_PREVIEW = 3'd1;
  localparam logic [2:0] MODE_CHECK = 3'd2;
  localparam logic [2:0] MODE_PRUNE = 3'd3;
  localparam logic [2:0] MODE_INSERT = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_EV,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_FIN0,
    S_FIN1,
    S_DONE
  } igf_state_t;
endpackage
`default_nettype wire

FILE: rtl/igf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module igf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/igf_scan.sv
// Scan accumulator: folds one gap entry per beat into the search results.
// Depends on igf_pkg.
`default_nettype none
module igf_scan import igf_pkg::*; #(
  parameter int MAX_GAPS = IGF_MAX_GAPS_DEF,
  parameter int TIME_BITS = IGF_TIME_BITS_DEF,
  localparam int AW = $clog2(MAX_GAPS),
  localparam int CW = $clog2(MAX_GAPS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clear,
  input  wire logic                 ev,
  input  wire logic [CW-1:0]        idx,
  input  wire logic [TIME_BITS-1:0] rd_begin,
  input  wire logic [TIME_BITS-1:0] rd_end,
  input  wire logic [TIME_BITS-1:0] key_t,
  input  wire logic [TIME_BITS-1:0] key_f,
  input  wire logic [TIME_BITS-1:0] dur,
  output logic      [CW-1:0]        le_cnt_r,
  output logic      [TIME_BITS-1:0] le_begin_r,
  output logic      [TIME_BITS-1:0] le_end_r,
  output logic      [CW-1:0]        lt_cnt_r,
  output logic      [TIME_BITS-1:0] lt_end_r,
  output logic                      nx_found_r,
  output logic      [TIME_BITS-1:0] nx_begin_r,
  output logic                      fit_found_r,
  output logic      [AW-1:0]        fit_idx_r,
  output logic      [TIME_BITS-1:0] fit_begin_r,
  output logic      [TIME_BITS-1:0] fit_end_r
);
  logic [CW-1:0] idx_p1;
  assign idx_p1 = idx + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      le_cnt_r <= '0;
      lt_cnt_r <= '0;
      nx_found_r <= 1'b0;
      fit_found_r <= 1'b0;
    end else if (ev) begin
      if (rd_begin <= key_t) begin
        le_cnt_r <= idx_p1;
        le_begin_r <= rd_begin;
        le_end_r <= rd_end;
      end else if (!fit_found_r && (rd_end - rd_begin) >= dur) begin
        fit_found_r <= 1'b1;
        fit_idx_r <= idx[AW-1:0];
        fit_begin_r <= rd_begin;
        fit_end_r <= rd_end;
      end
      if (rd_begin < key_f) begin
        lt_cnt_r <= idx_p1;
        lt_end_r <= rd_end;
      end else if (!nx_found_r) begin
        nx_found_r <= 1'b1;
        nx_begin_r <= rd_begin;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/idle_gap_first_fit_reserver.sv
// Top level of the idle-gap first-fit reserver: controller, decision logic, shifter.
// Depends on igf_pkg, igf_ram, igf_scan.
//
// channel | ports                                          | handshake
// input   | in_mode in_time_value in_duration in_gap_end   | start && !busy
// result  | out_start_time out_fits out_status             | out_valid, one cycle
//
// An item scans each held gap with a read of the gap RAM, decides, then moves
// the entries that shift, one read and one write each, and writes up to two new
// entries: the gap RAM, with one read and one write port, sets the pace. busy
// stays high from accept until the result cycle. The receiver cannot stall; reset
// is synchronous and clears the held count, frontier and watermark, the gap RAM itself is not cleared.
`default_nettype none
module idle_gap_first_fit_reserver import igf_pkg::*; #(
  parameter int MAX_GAPS = IGF_MAX_GAPS_DEF,
  parameter int TIME_BITS = IGF_TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           in_mode,
  input  wire logic [TIME_BITS-1:0] in_time_value,
  input  wire logic [TIME_BITS-1:0] in_duration,
  input  wire logic [TIME_BITS-1:0] in_gap_end,
  output logic                      out_valid,
  output logic      [TIME_BITS-1:0] out_start_time,
  output logic                      out_fits,
  output logic      [2:0]           out_status
);
  localparam int AW = $clog2(MAX_GAPS);
  localparam int CW = $clog2(MAX_GAPS + 1);
  localparam int TB = TIME_BITS;

  igf_state_t state_r, state_nxt;

  logic [2:0]    mode_r;
  logic [TB-1:0] t_r, d_r, g_r;
  logic [CW-1:0] held_r, held_nxt;
  logic [TB-1:0] fr_r, fr_nxt, wm_r, wm_nxt;
  logic [CW-1:0] sc_idx_r;

  logic          sh_left_r, sh_left_nxt;
  logic [CW-1:0] sh_src_r, sh_src_nxt, sh_cnt_r, sh_cnt_nxt, sh_k_r, sh_k_nxt;
  logic [CW-1:0] sh_dn, sh_up;
  logic          w0_v_r, w0_v_nxt, w1_v_r, w1_v_nxt;
  logic [CW-1:0] w0_a_r, w0_a_nxt, w1_a_r, w1_a_nxt;
  logic [2*TB-1:0] w0_d_r, w0_d_nxt, w1_d_r, w1_d_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [TB-1:0] so_r, so_nxt;
  logic          fits_r, fits_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [2*TB-1:0] mem_wdata, mem_rdata;

  logic          scan_clr, scan_ev;
  logic [TB-1:0] key_f;
  logic [CW-1:0] le_cnt, lt_cnt;
  logic [TB-1:0] le_begin, le_end, lt_end, nx_begin, fit_begin, fit_end;
  logic          nx_found, fit_found;
  logic [AW-1:0] fit_idx;

  igf_ram #(.WIDTH(2 * TB), .DEPTH(MAX_GAPS)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign key_f = (mode_r == MODE_RESERVE || mode_r == MODE_PREVIEW) ? fr_r : t_r;

  igf_scan #(.MAX_GAPS(MAX_GAPS), .TIME_BITS(TB)) u_scan (
    .clk(clk), .rst_n(rst_n), .clear(scan_clr), .ev(scan_ev), .idx(sc_idx_r),
    .rd_begin(mem_rdata[2*TB-1:TB]), .rd_end(mem_rdata[TB-1:0]),
    .key_t(t_r), .key_f(key_f), .dur(d_r),
    .le_cnt_r(le_cnt), .le_begin_r(le_begin), .le_end_r(le_end),
    .lt_cnt_r(lt_cnt), .lt_end_r(lt_end), .nx_found_r(nx_found),
    .nx_begin_r(nx_begin), .fit_found_r(fit_found), .fit_idx_r(fit_idx),
    .fit_begin_r(fit_begin), .fit_end_r(fit_end)
  );

  assign sh_dn = sh_src_r - sh_k_r;
  assign sh_up = sh_src_r + CW'(1);

  // decision datapath
  logic          invalid_q, full, le_ok, use_gap, head, tail, ovl;
  logic [TB:0]   sum_td, fsum;
  logic [TB-1:0] gb, ge, gstart, gfin, fstart, ins_b, ins_e;
  logic [CW-1:0] gi, first;
  logic          keep;

  always_comb begin
    invalid_q = (d_r == '0) || (t_r < wm_r);
    full = held_r >= CW'(MAX_GAPS);
    sum_td = {1'b0, t_r} + {1'b0, d_r};
    le_ok = (le_cnt != '0) && (t_r <= le_end) && ((le_end - t_r) >= d_r);
    use_gap = (t_r < fr_r) && (le_ok || fit_found);
    gb = le_ok ? le_begin : fit_begin;
    ge = le_ok ? le_end : fit_end;
    gi = le_ok ? (le_cnt - CW'(1)) : CW'(fit_idx);
    gstart = (gb > t_r) ? gb : t_r;
    gfin = gstart + d_r;
    head = gb < gstart;
    tail = gfin < ge;
    fstart = (t_r > fr_r) ? t_r : fr_r;
    fsum = {1'b0, fstart} + {1'b0, d_r};
    ins_b = (mode_r == MODE_INSERT) ? t_r : fr_r;
    ins_e = (mode_r == MODE_INSERT) ? g_r : fstart;
    ovl = ((lt_cnt != '0) && (lt_end > ins_b)) || (nx_found && (nx_begin < ins_e));
    keep = (lt_cnt != '0) && (lt_end > t_r);
    first = keep ? (lt_cnt - CW'(1)) : lt_cnt;
  end

  always_comb begin
    held_nxt = held_r;
    fr_nxt = fr_r;
    wm_nxt = wm_r;
    sh_left_nxt = 1'b0;
    sh_src_nxt = '0;
    sh_cnt_nxt = '0;
    sh_k_nxt = CW'(1);
    w0_v_nxt = 1'b0;
    w0_a_nxt = '0;
    w0_d_nxt = '0;
    w1_v_nxt = 1'b0;
    w1_a_nxt = '0;
    w1_d_nxt = '0;
    st_nxt = ST_OK;
    so_nxt = '0;
    fits_nxt = 1'b0;
    case (mode_r)
      MODE_RESERVE, MODE_PREVIEW: begin
        if (invalid_q) begin
          st_nxt = ST_INVALID;
        end else if (use_gap) begin
          if (mode_r == MODE_PREVIEW) begin
            so_nxt = gstart;
          end else if (head && tail) begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              so_nxt = gstart;
              w0_v_nxt = 1'b1;
              w0_a_nxt = gi;
              w0_d_nxt = {gb, gstart};
              sh_src_nxt = held_r - CW'(1);
              sh_cnt_nxt = held_r - gi - CW'(1);
              w1_v_nxt = 1'b1;
              w1_a_nxt = gi + CW'(1);
              w1_d_nxt = {gfin, ge};
              held_nxt = held_r + CW'(1);
            end
          end else if (head) begin
            so_nxt = gstart;
            w0_v_nxt = 1'b1;
            w0_a_nxt = gi;
            w0_d_nxt = {gb, gstart};
          end else if (tail) begin
            so_nxt = gstart;
            w0_v_nxt = 1'b1;
            w0_a_nxt = gi;
            w0_d_nxt = {gfin, ge};
          end else begin
            so_nxt = gstart;
            sh_left_nxt = 1'b1;
            sh_src_nxt = gi + CW'(1);
            sh_cnt_nxt = held_r - gi - CW'(1);
            held_nxt = held_r - CW'(1);
          end
        end else if (fsum[TB]) begin
          st_nxt = ST_OVERFLOW;
        end else if (mode_r == MODE_PREVIEW) begin
          so_nxt = fstart;
        end else if (fstart > fr_r) begin
          if (ovl) begin
            st_nxt = ST_OVERLAP;
          end else if (full) begin
            st_nxt = ST_FULL;
          end else begin
            so_nxt = fstart;
            sh_src_nxt = held_r - CW'(1);
            sh_cnt_nxt = held_r - lt_cnt;
            w1_v_nxt = 1'b1;
            w1_a_nxt = lt_cnt;
            w1_d_nxt = {fr_r, fstart};
            held_nxt = held_r + CW'(1);
            fr_nxt = fsum[TB-1:0];
          end
        end else begin
          so_nxt = fstart;
          fr_nxt = fsum[TB-1:0];
        end
      end
      MODE_CHECK: begin
        if (invalid_q) begin
          st_nxt = ST_INVALID;
        end else if (sum_td[TB]) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          fits_nxt = (t_r >= fr_r) || le_ok;
        end
      end
      MODE_PRUNE: begin
        if (t_r > wm_r) begin
          if (first != '0) begin
            sh_left_nxt = 1'b1;
            sh_src_nxt = first;
            sh_cnt_nxt = held_r - first;
            sh_k_nxt = first;
            held_nxt = held_r - first;
          end
          w1_v_nxt = keep;
          w1_a_nxt = '0;
          w1_d_nxt = {t_r, lt_end};
          wm_nxt = t_r;
          fr_nxt = (fr_r < t_r) ? t_r : fr_r;
        end
      end
      MODE_INSERT: begin
        if (g_r <= t_r || t_r < wm_r) begin
          st_nxt = ST_INVALID;
        end else if (ovl) begin
          st_nxt = ST_OVERLAP;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          sh_src_nxt = held_r - CW'(1);
          sh_cnt_nxt = held_r - lt_cnt;
          w1_v_nxt = 1'b1;
          w1_a_nxt = lt_cnt;
          w1_d_nxt = {t_r, g_r};
          held_nxt = held_r + CW'(1);
        end
      end
      default: begin
        st_nxt = ST_INVALID;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (held_r == '0) ? S_DECIDE : S_SC_RD;
        end
      end
      S_SC_RD: state_nxt = S_SC_EV;
      S_SC_EV: begin
        state_nxt = (sc_idx_r + CW'(1) == held_r) ? S_DECIDE : S_SC_RD;
      end
      S_DECIDE: state_nxt = S_SH_RD;
      S_SH_RD: begin
        state_nxt = (sh_cnt_r == '0) ? S_FIN0 : S_SH_WR;
      end
      S_SH_WR: state_nxt = S_SH_RD;
      S_FIN0: state_nxt = S_FIN1;
      S_FIN1: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = 1'b1;
    out_valid = 1'b0;
    scan_clr = 1'b0;
    scan_ev = 1'b0;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        scan_clr = start;
      end
      S_SC_RD: mem_raddr = sc_idx_r[AW-1:0];
      S_SC_EV: scan_ev = 1'b1;
      S_SH_RD: mem_raddr = sh_src_r[AW-1:0];
      S_SH_WR: begin
        mem_we = 1'b1;
        mem_waddr = sh_left_r ? sh_dn[AW-1:0] : sh_up[AW-1:0];
      end
      S_FIN0: begin
        mem_we = w0_v_r;
        mem_waddr = w0_a_r[AW-1:0];
        mem_wdata = w0_d_r;
      end
      S_FIN1: begin
        mem_we = w1_v_r;
        mem_waddr = w1_a_r[AW-1:0];
        mem_wdata = w1_d_r;
      end
      S_DONE: out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign out_start_time = so_r;
  assign out_fits = fits_r;
  assign out_status = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r <= '0;
      fr_r <= '0;
      wm_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DECIDE) begin
        held_r <= held_nxt;
        fr_r <= fr_nxt;
        wm_r <= wm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        mode_r <= in_mode;
        t_r <= in_time_value;
        d_r <= in_duration;
        g_r <= in_gap_end;
        sc_idx_r <= '0;
      end
      S_SC_EV: sc_idx_r <= sc_idx_r + CW'(1);
      S_DECIDE: begin
        sh_left_r <= sh_left_nxt;
        sh_src_r <= sh_src_nxt;
        sh_cnt_r <= sh_cnt_nxt;
        sh_k_r <= sh_k_nxt;
        w0_v_r <= w0_v_nxt;
        w0_a_r <= w0_a_nxt;
        w0_d_r <= w0_d_nxt;
        w1_v_r <= w1_v_nxt;
        w1_a_r <= w1_a_nxt;
        w1_d_r <= w1_d_nxt;
        st_r <= st_nxt;
        so_r <= so_nxt;
        fits_r <= fits_nxt;
      end
      S_SH_WR: begin
        sh_src_r <= sh_left_r ? (sh_src_r + CW'(1)) : (sh_src_r - CW'(1));
        sh_cnt_r <= sh_cnt_r - CW'(1);
      end
      default: begin
        sh_cnt_r <= sh_cnt_r;
      end
    endcase
  end
endmodule
`default_nettype wire
